[rtl/akf_pkg.sv]
// Package for the angle Kalman filter: widths, register map, reset values,
// sequencer state types and the saturation helper.
// No dependencies.
package akf_pkg;

    // Data widths.
    localparam int DW = 32;   // angles, rates, covariances, gains
    localparam int CW = 31;   // configuration registers
    localparam int TW = 16;   // time step
    localparam int PW = 36;   // shifted product
    localparam int AW = 38;   // adder width before saturation
    localparam int MW = 33;   // multiplier operand width
    localparam int SW = 33;   // innovation variance
    localparam int QW = 31;   // quotient bits below the overflow check
    localparam int NW = 5;    // divider iteration counter

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_QA = 2'd0;
    localparam logic [1:0] REG_QB = 2'd1;
    localparam logic [1:0] REG_R  = 2'd2;

    localparam logic [CW-1:0] QA_RESET = 31'd268435;
    localparam logic [CW-1:0] QB_RESET = 31'd805306;
    localparam logic [CW-1:0] R_RESET  = 31'd8053064;

    localparam logic signed [DW-1:0] DMAX = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] DMIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        DP_INIT,
        DP_ITER,
        DP_FIN
    } t_dphase;

    // Micro-steps of the filter update. Names starting with S_M_ load the product
    // register, S_S forms the innovation variance, the others run the saturating adder.
    typedef enum logic [4:0] {
        S_RATE,
        S_M_DTRATE,
        S_ANG1,
        S_M_DTBB,
        S_T,
        S_AB1,
        S_BA1,
        S_M_DTT,
        S_AA1,
        S_M_DTQB,
        S_BB1,
        S_Y,
        S_S,
        S_M_K0Y,
        S_ANG2,
        S_M_K1Y,
        S_BIAS,
        S_M_K1AA,
        S_BA2,
        S_M_K0AA,
        S_AA2,
        S_M_K1AB,
        S_BB2,
        S_M_K0AB,
        S_AB2
    } t_step;

    // Clamp a wide sum to the signed 32-bit range.
    function automatic logic signed [DW-1:0] sat32(input logic signed [AW-1:0] x);
        logic signed [DW-1:0] r;
        if (x > AW'(DMAX)) begin
            r = DMAX;
        end else if (x < AW'(DMIN)) begin
            r = DMIN;
        end else begin
            r = x[DW-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/angle_kalman_filter.sv]
// Two-state (angle, gyro bias) Kalman filter top level.
// Depends on akf_pkg.

// From acceptance until its result is presented, one item goes through 25
// sequencer steps on one shared 33x33 multiplier and one saturating adder,
// two gain divisions in a bit-serial restoring divider, and a load of the
// output register. When the innovation variance is not positive, both
// divisions are skipped. The block takes no new item while one is in work,
// and a finished result waits in the output register until it is taken.
module angle_kalman_filter
    import akf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [DW-1:0]  i_measured_angle,
    input  logic signed [DW-1:0]  i_measured_rate,
    input  logic [TW-1:0]         i_time_step,
    // Output channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [DW-1:0]  o_filtered_angle,
    output logic signed [DW-1:0]  o_corrected_rate,
    output logic signed [DW-1:0]  o_bias_estimate,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_state  r_state, n_state;
    t_step   r_step;
    t_dphase r_dphase;

    logic [CW-1:0] r_qa, r_qb, r_r;

    logic signed [DW-1:0] r_angle, r_bias, r_paa, r_pab, r_pba, r_pbb;
    logic signed [DW-1:0] r_rate, r_t, r_y, r_k0, r_k1;
    logic signed [DW-1:0] r_m_angle, r_m_rate;
    logic [TW-1:0]        r_dt;
    logic signed [SW-1:0] r_s;
    logic signed [PW-1:0] r_prod;

    // Divider state.
    logic          r_div_sel;
    logic          r_neg, r_ovf;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_dsh, r_quo;
    logic [NW-1:0] r_div_cnt;

    logic                 r_o_valid;
    logic signed [DW-1:0] r_o_angle, r_o_rate, r_o_bias;

    logic in_accept, out_free, cfg_write;

    logic signed [MW-1:0]    mul_a, mul_b;
    logic                    mul_sh28;
    logic signed [2*MW-1:0]  prod_full;
    logic signed [PW-1:0]    prod_sh;

    logic signed [AW-1:0] add_a, add_b, add_c, add_d;
    logic signed [DW-1:0] sum_sat;

    logic                 s_pos;
    logic signed [DW-1:0] div_src;
    logic [DW:0]          div_abs;
    logic [SW-1:0]        rem2;
    logic [DW-1:0]        s_u;
    logic signed [DW-1:0] k_res;

    // Handshakes.
    assign in_accept = i_valid && (r_state == ST_IDLE);
    assign out_free  = !r_o_valid || !i_stall;
    assign cfg_write = psel && penable && pwrite;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_CALC;
            end
            ST_CALC: begin
                if (r_step == S_S) begin
                    n_state = ST_DIV;
                end else if (r_step == S_AB2) begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                if (r_dphase == DP_INIT && !s_pos) begin
                    n_state = ST_CALC;
                end else if (r_dphase == DP_FIN && r_div_sel) begin
                    n_state = ST_CALC;
                end
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_stall          = (r_state != ST_IDLE);
        o_valid          = r_o_valid;
        o_filtered_angle = r_o_angle;
        o_corrected_rate = r_o_rate;
        o_bias_estimate  = r_o_bias;
        pready           = 1'b1;
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[3:2])
            REG_QA:  prdata = {1'b0, r_qa};
            REG_QB:  prdata = {1'b0, r_qb};
            REG_R:   prdata = {1'b0, r_r};
            default: prdata = '0;
        endcase
    end

    // Operand selection for the shared multiplier and adder.
    always_comb begin
        mul_a    = MW'(signed'({1'b0, r_dt}));
        mul_b    = MW'(r_rate);
        mul_sh28 = 1'b0;
        add_a    = AW'(r_prod);
        add_b    = '0;
        add_c    = '0;
        add_d    = '0;
        case (r_step) inside
            S_M_DTRATE: mul_b = MW'(r_rate);
            S_M_DTBB:   mul_b = MW'(r_pbb);
            S_M_DTT:    mul_b = MW'(r_t);
            S_M_DTQB:   mul_b = MW'(signed'({1'b0, r_qb}));
            S_M_K0Y: begin
                mul_a = MW'(r_k0); mul_b = MW'(r_y); mul_sh28 = 1'b1;
            end
            S_M_K1Y: begin
                mul_a = MW'(r_k1); mul_b = MW'(r_y); mul_sh28 = 1'b1;
            end
            S_M_K1AA: begin
                mul_a = MW'(r_k1); mul_b = MW'(r_paa); mul_sh28 = 1'b1;
            end
            S_M_K0AA: begin
                mul_a = MW'(r_k0); mul_b = MW'(r_paa); mul_sh28 = 1'b1;
            end
            S_M_K1AB: begin
                mul_a = MW'(r_k1); mul_b = MW'(r_pab); mul_sh28 = 1'b1;
            end
            S_M_K0AB: begin
                mul_a = MW'(r_k0); mul_b = MW'(r_pab); mul_sh28 = 1'b1;
            end
            S_RATE: begin
                add_a = AW'(r_m_rate); add_b = -AW'(r_bias);
            end
            S_ANG1, S_ANG2: add_b = AW'(r_angle);
            S_T: begin
                add_b = -AW'(r_pab);
                add_c = -AW'(r_pba);
                add_d = AW'(signed'({1'b0, r_qa}));
            end
            S_AB1, S_AB2: begin
                add_a = -AW'(r_prod); add_b = AW'(r_pab);
            end
            S_BA1, S_BA2: begin
                add_a = -AW'(r_prod); add_b = AW'(r_pba);
            end
            S_AA1: add_b = AW'(r_paa);
            S_AA2: begin
                add_a = -AW'(r_prod); add_b = AW'(r_paa);
            end
            S_BB1: add_b = AW'(r_pbb);
            S_BB2: begin
                add_a = -AW'(r_prod); add_b = AW'(r_pbb);
            end
            S_Y: begin
                add_a = AW'(r_m_angle); add_b = -AW'(r_angle);
            end
            S_BIAS: add_b = AW'(r_bias);
            default: add_b = '0;
        endcase
    end

    // Shared multiplier with a floor shift, and the saturating adder.
    assign prod_full = mul_a * mul_b;
    assign prod_sh   = mul_sh28 ? PW'(prod_full >>> 28) : PW'(prod_full >>> 16);
    assign sum_sat   = sat32(add_a + add_b + add_c + add_d);

    // Divider datapath: magnitude of the dividend, one restoring step, result.
    assign s_pos   = !r_s[SW-1] && (r_s != '0);
    assign s_u     = r_s[DW-1:0];
    assign div_src = r_div_sel ? r_pba : r_paa;
    assign div_abs = div_src[DW-1] ? -{div_src[DW-1], div_src} : {1'b0, div_src};
    assign rem2    = {r_rem, r_dsh[QW-1]};

    always_comb begin
        if (r_ovf) begin
            k_res = r_neg ? DMIN : DMAX;
        end else if (r_neg) begin
            k_res = -DW'(signed'({1'b0, r_quo}));
        end else begin
            k_res = DW'(signed'({1'b0, r_quo}));
        end
    end

    // State register and sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= S_RATE;
            r_dphase  <= DP_INIT;
            r_div_sel <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                r_step <= S_RATE;
            end else if (r_state == ST_CALC) begin
                r_step <= t_step'(r_step + 5'd1);
            end
            if (r_state == ST_CALC && r_step == S_S) begin
                r_dphase  <= DP_INIT;
                r_div_sel <= 1'b0;
            end else if (r_state == ST_DIV) begin
                unique case (r_dphase)
                    DP_INIT: if (s_pos) r_dphase <= DP_ITER;
                    DP_ITER: if (r_div_cnt == NW'(QW - 1)) r_dphase <= DP_FIN;
                    DP_FIN: begin
                        r_dphase  <= DP_INIT;
                        r_div_sel <= 1'b1;
                    end
                    default: r_dphase <= DP_INIT;
                endcase
            end
            if (r_state == ST_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= QA_RESET;
            r_qb <= QB_RESET;
            r_r  <= R_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_QA:  r_qa <= pwdata[CW-1:0];
                REG_QB:  r_qb <= pwdata[CW-1:0];
                REG_R:   r_r  <= pwdata[CW-1:0];
                default: r_qa <= r_qa;
            endcase
        end
    end

    // Filter state and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_bias  <= '0;
            r_paa   <= '0;
            r_pab   <= '0;
            r_pba   <= '0;
            r_pbb   <= '0;
        end else if (in_accept) begin
            r_m_angle <= i_measured_angle;
            r_m_rate  <= i_measured_rate;
            r_dt      <= i_time_step;
        end else if (r_state == ST_CALC) begin
            case (r_step) inside
                S_RATE:          r_rate  <= sum_sat;
                S_ANG1, S_ANG2:  r_angle <= sum_sat;
                S_T:             r_t     <= sum_sat;
                S_AB1, S_AB2:    r_pab   <= sum_sat;
                S_BA1, S_BA2:    r_pba   <= sum_sat;
                S_AA1, S_AA2:    r_paa   <= sum_sat;
                S_BB1, S_BB2:    r_pbb   <= sum_sat;
                S_Y:             r_y     <= sum_sat;
                S_BIAS:          r_bias  <= sum_sat;
                S_S:             r_s     <= SW'(r_paa) + SW'(signed'({1'b0, r_r}));
                default:         r_prod  <= prod_sh;
            endcase
        end else if (r_state == ST_DIV) begin
            case (r_dphase)
                DP_INIT: begin
                    if (!s_pos) begin
                        r_k0 <= '0;
                        r_k1 <= '0;
                    end
                    r_neg     <= div_src[DW-1];
                    r_ovf     <= (div_abs >> 3) >= {1'b0, s_u};
                    r_rem     <= DW'(div_abs >> 3);
                    r_dsh     <= {div_abs[2:0], 28'd0};
                    r_quo     <= '0;
                    r_div_cnt <= '0;
                end
                DP_ITER: begin
                    if (rem2 >= {1'b0, s_u}) begin
                        r_rem <= DW'(rem2 - {1'b0, s_u});
                        r_quo <= {r_quo[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem2[DW-1:0];
                        r_quo <= {r_quo[QW-2:0], 1'b0};
                    end
                    r_dsh     <= {r_dsh[QW-2:0], 1'b0};
                    r_div_cnt <= r_div_cnt + NW'(1);
                end
                DP_FIN: begin
                    if (r_div_sel) begin
                        r_k1 <= k_res;
                    end else begin
                        r_k0 <= k_res;
                    end
                end
                default: r_div_cnt <= '0;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_o_angle <= r_angle;
            r_o_rate  <= r_rate;
            r_o_bias  <= r_bias;
        end
    end

endmodule
